>>> rtl/pnss_pkg.sv
// ----------------------------------------------------------------------------
// pnss_pkg: shared types and constants of the positive neighbor sum stencil
// Default sizes, field widths, input kind and register index codes, and the
// control word that rides with a cell from the line store read to the output.
// ----------------------------------------------------------------------------
package pnss_pkg;

    // Default sizes handed to the top level
    localparam int DEF_MAX_ROWS   = 128;
    localparam int DEF_MAX_COLS   = 128;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed widths of the stream and register fields
    localparam int SAMPLE_W = 32;
    localparam int SUM_OUT_W = 33;
    localparam int POS_W    = 7;
    localparam int DIM_W    = 8;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;
    localparam int M_DATA_W = 48;

    // Meaning of the input beat's tuser bit
    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_DRAIN  = 1'b1
    } kind_t;

    // Register index (byte address bit 2)
    typedef enum logic {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } reg_idx_t;

    // Control that travels with a stepped cell into the read-data stage
    typedef struct packed {
        logic             emit;
        logic             up_en;
        logic             down_en;
        logic             left_en;
        logic             right_en;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             final_cell;
    } cell_ctl_t;

endpackage

>>> rtl/pnss_ram.sv
// ----------------------------------------------------------------------------
// pnss_ram: generic simple RAM, one write port and two registered read ports
// Read data updates only on a read enable and holds otherwise.
// ----------------------------------------------------------------------------
module pnss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 257
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> rtl/positive_neighbor_sum_stencil.sv
// ----------------------------------------------------------------------------
// positive_neighbor_sum_stencil: four-neighbor positive sum over a raster stream
// For each cell of a row_count x col_count matrix, emit the sum of its up,
// down, left and right neighbors that exist and are strictly positive.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle and gives at most one result beat per
// cycle; the beat causing a result (the sample one row below the cell, or a
// drain beat once the whole matrix is in) passes the read stage and output
// register. The rate is set by the line store, a 2*MAX_COLS+1 entry RAM with
// one write and two read addresses per beat: the up neighbor and the right
// neighbor come from it, the down neighbor is the sample on the input, and
// the left neighbor is held in a short register chain. Input backs up only
// while a result waits in the output register and another one is ready behind
// it. Writing either register restarts the matrix; write registers only
// while the block is idle. The line store needs no clearing pass after reset.
module positive_neighbor_sum_stencil #(
    parameter int MAX_ROWS   = pnss_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = pnss_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = pnss_pkg::DEF_DATA_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pnss_pkg::SAMPLE_W-1:0] s_tdata,  // [31:0] sample
    input  logic                          s_tuser,  // [0] kind
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [32:0] neighbor_sum, [39:33] cell_row, [46:40] cell_col, [47] final_cell
    output logic [pnss_pkg::M_DATA_W-1:0] m_tdata,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pnss_pkg::APB_AW-1:0]   paddr,
    input  logic [pnss_pkg::APB_DW-1:0]   pwdata,
    output logic [pnss_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int STORE_DEPTH = 2 * MAX_COLS + 1;
    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int SP_W   = AW + 1;
    localparam int RU_W   = $clog2(MAX_ROWS + 1);
    localparam int CU_W   = $clog2(MAX_COLS + 1);
    localparam int RI_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CI_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int SUM_W  = DATA_WIDTH + 1;
    localparam int DIM_W  = pnss_pkg::DIM_W;

    // Registers
    logic [DIM_W-1:0]       row_count_reg;
    logic [DIM_W-1:0]       col_count_reg;
    logic [CNT_W-1:0]       acc_reg;
    logic [CNT_W-1:0]       emitted_reg;
    logic [RI_W-1:0]        emit_row_reg;
    logic [CI_W-1:0]        emit_col_reg;
    logic [AW-1:0]          wr_ptr_reg;
    logic                   s1_valid_reg;
    pnss_pkg::cell_ctl_t    s1_ctl_reg;
    logic [DATA_WIDTH-1:0]  s1_down_reg;
    logic [DATA_WIDTH-1:0]  center_reg;
    logic [DATA_WIDTH-1:0]  left_reg;
    logic                   m_valid_reg;
    logic [pnss_pkg::M_DATA_W-1:0] m_data_reg;

    // Next values
    logic [CNT_W-1:0]       acc_next;
    logic [CNT_W-1:0]       emitted_next;
    logic [RI_W-1:0]        emit_row_next;
    logic [CI_W-1:0]        emit_col_next;
    logic [AW-1:0]          wr_ptr_next;
    pnss_pkg::cell_ctl_t    s1_ctl_next;

    // Derived dimensions
    logic [RU_W-1:0]        rows_used;
    logic [CU_W-1:0]        cols_used;
    logic [CNT_W-1:0]       total;
    logic [SP_W-1:0]        span;
    logic [SP_W-1:0]        rt_off;
    logic [SP_W:0]          rt_sum;
    logic [AW-1:0]          up_ptr;
    logic [AW-1:0]          rt_ptr;

    // Stepping
    logic                   cfg_wr;
    logic                   step_sample;
    logic                   step_drain;
    logic                   take;
    logic                   emit_now;
    logic                   s1_go;

    // Read stage
    logic [DATA_WIDTH-1:0]  rd_up;
    logic [DATA_WIDTH-1:0]  rd_rt;
    logic [SUM_W-1:0]       sum_val;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (pnss_pkg::reg_idx_t'(paddr[2]))
            pnss_pkg::REG_ROW_COUNT: prdata = pnss_pkg::APB_DW'(row_count_reg);
            pnss_pkg::REG_COL_COUNT: prdata = pnss_pkg::APB_DW'(col_count_reg);
            default:                 prdata = '0;
        endcase
    end

    // Clamp the dimensions and derive the matrix size and store span
    always_comb begin
        if (row_count_reg == '0) begin
            rows_used = RU_W'(1);
        end else if (32'(row_count_reg) > 32'(MAX_ROWS)) begin
            rows_used = RU_W'(MAX_ROWS);
        end else begin
            rows_used = RU_W'(row_count_reg);
        end
        if (col_count_reg == '0) begin
            cols_used = CU_W'(1);
        end else if (32'(col_count_reg) > 32'(MAX_COLS)) begin
            cols_used = CU_W'(MAX_COLS);
        end else begin
            cols_used = CU_W'(col_count_reg);
        end
        total = CNT_W'(CNT_W'(rows_used) * CNT_W'(cols_used));
        span  = SP_W'({SP_W'(cols_used), 1'b1});
    end

    // Store addresses: the up neighbor sits one past the write slot, the
    // right neighbor cols+2 past it (modulo span)
    always_comb begin
        if (SP_W'(wr_ptr_reg) + SP_W'(1) == span) begin
            wr_ptr_next = '0;
        end else begin
            wr_ptr_next = AW'(SP_W'(wr_ptr_reg) + SP_W'(1));
        end
        up_ptr = wr_ptr_next;
        if (cols_used > CU_W'(1)) begin
            rt_off = SP_W'(cols_used) + SP_W'(2);
        end else begin
            rt_off = '0;
        end
        rt_sum = (SP_W + 1)'(wr_ptr_reg) + (SP_W + 1)'(rt_off);
        if (rt_sum >= (SP_W + 1)'(span)) begin
            rt_ptr = AW'(rt_sum - (SP_W + 1)'(span));
        end else begin
            rt_ptr = AW'(rt_sum);
        end
    end

    // ------------------------------------------------------------------
    // Input beat decode
    // ------------------------------------------------------------------
    assign s1_go    = !s1_ctl_reg.emit || !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_go;

    always_comb begin
        step_sample = (pnss_pkg::kind_t'(s_tuser) == pnss_pkg::KIND_SAMPLE)
                      && (acc_reg < total);
        step_drain  = (pnss_pkg::kind_t'(s_tuser) == pnss_pkg::KIND_DRAIN)
                      && (acc_reg == total) && (emitted_reg < total);
        take        = s_tvalid && s_tready && (step_sample || step_drain);
        emit_now    = step_drain
                      || (step_sample && (emitted_reg < total)
                          && ((CNT_W + 1)'(acc_reg) + (CNT_W + 1)'(1)
                              > (CNT_W + 1)'(emitted_reg) + (CNT_W + 1)'(cols_used)));

        // Cell control for the read stage
        s1_ctl_next.emit       = emit_now;
        s1_ctl_next.up_en      = emit_row_reg != '0;
        s1_ctl_next.down_en    = (32'(emit_row_reg) + 32'd1) < 32'(rows_used);
        s1_ctl_next.left_en    = emit_col_reg != '0;
        s1_ctl_next.right_en   = (32'(emit_col_reg) + 32'd1) < 32'(cols_used);
        s1_ctl_next.row        = pnss_pkg::POS_W'(emit_row_reg);
        s1_ctl_next.col        = pnss_pkg::POS_W'(emit_col_reg);
        s1_ctl_next.final_cell = ((CNT_W + 1)'(emitted_reg) + (CNT_W + 1)'(1))
                                 == (CNT_W + 1)'(total);

        // Advance counters
        acc_next      = step_sample ? acc_reg + CNT_W'(1) : acc_reg;
        emitted_next  = emitted_reg;
        emit_row_next = emit_row_reg;
        emit_col_next = emit_col_reg;
        if (emit_now) begin
            emitted_next = emitted_reg + CNT_W'(1);
            if ((32'(emit_col_reg) + 32'd1) >= 32'(cols_used)) begin
                emit_col_next = '0;
                emit_row_next = emit_row_reg + RI_W'(1);
            end else begin
                emit_col_next = emit_col_reg + CI_W'(1);
            end
        end
    end

    // Counters and pointers; a register write restarts the matrix
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= DIM_W'(1);
            col_count_reg <= DIM_W'(1);
            acc_reg       <= '0;
            emitted_reg   <= '0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            wr_ptr_reg    <= '0;
        end else if (cfg_wr) begin
            unique case (pnss_pkg::reg_idx_t'(paddr[2]))
                pnss_pkg::REG_ROW_COUNT: row_count_reg <= pwdata[DIM_W-1:0];
                pnss_pkg::REG_COL_COUNT: col_count_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
            acc_reg      <= '0;
            emitted_reg  <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
            wr_ptr_reg   <= '0;
        end else if (take) begin
            acc_reg      <= acc_next;
            emitted_reg  <= emitted_next;
            emit_row_reg <= emit_row_next;
            emit_col_reg <= emit_col_next;
            wr_ptr_reg   <= wr_ptr_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store
    // ------------------------------------------------------------------
    pnss_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .we      (take && step_sample),
        .waddr   (wr_ptr_reg),
        .wdata   (s_tdata[DATA_WIDTH-1:0]),
        .re      (take),
        .raddr_a (up_ptr),
        .raddr_b (rt_ptr),
        .rdata_a (rd_up),
        .rdata_b (rd_rt)
    );

    // Read stage control: load when the stage moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_ctl_reg   <= '0;
        end else if (s_tready) begin
            s1_valid_reg <= take;
            s1_ctl_reg   <= s1_ctl_next;
        end
    end

    // Down neighbor is the sample that arrives with the step
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            s1_down_reg <= s_tdata[DATA_WIDTH-1:0];
        end
    end

    // Middle row chain: shift the right neighbor into center, then left
    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_go) begin
            left_reg   <= center_reg;
            center_reg <= rd_rt;
        end
    end

    // Sum the positive existing neighbors
    always_comb begin
        sum_val = '0;
        if (s1_ctl_reg.up_en && !rd_up[DATA_WIDTH-1]) begin
            sum_val = sum_val + SUM_W'(rd_up);
        end
        if (s1_ctl_reg.down_en && !s1_down_reg[DATA_WIDTH-1]) begin
            sum_val = sum_val + SUM_W'(s1_down_reg);
        end
        if (s1_ctl_reg.left_en && !left_reg[DATA_WIDTH-1]) begin
            sum_val = sum_val + SUM_W'(left_reg);
        end
        if (s1_ctl_reg.right_en && !rd_rt[DATA_WIDTH-1]) begin
            sum_val = sum_val + SUM_W'(rd_rt);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_valid_reg && s1_ctl_reg.emit && s1_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_ctl_reg.emit && s1_go) begin
            m_data_reg <= {s1_ctl_reg.final_cell, s1_ctl_reg.col, s1_ctl_reg.row,
                           pnss_pkg::SUM_OUT_W'(sum_val)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> test/stencil_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stencil_sum_checker: result predictor and comparator for the stencil block
// Watches register writes and accepted input beats, predicts each cell's
// positive neighbor sum with its position and last-cell flag, and compares
// every accepted result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module stencil_sum_checker
    import pnss_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
    input  logic                s_tuser,   // [0] kind
    input  logic                m_tvalid,
    input  logic                m_tready,
    // [32:0] neighbor_sum, [39:33] cell_row, [46:40] cell_col, [47] final_cell
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    input  logic                pready,
    output int                  mismatch_count,
    output int                  cells_outstanding
);

    localparam int STORE_DEPTH = 2 * MAX_COLS + 1;

    typedef struct packed {
        logic [SUM_OUT_W-1:0] sum;
        logic [POS_W-1:0]     row;
        logic [POS_W-1:0]     col;
        logic                 final_cell;
    } cell_sum_t;

    cell_sum_t           expected_cells[$];
    logic [SAMPLE_W-1:0] line_mem [STORE_DEPTH];
    int unsigned         samples_taken;
    int unsigned         cells_sent;
    int unsigned         next_row;
    int unsigned         next_col;
    logic [DIM_W-1:0]    rows_reg;
    logic [DIM_W-1:0]    cols_reg;
    int                  errors = 0;

    // Zero counts as one, anything past the maximum as the maximum
    function automatic int unsigned dim_in_use(logic [DIM_W-1:0] value, int unsigned limit);
        if (value == 0) return 1;
        if (value > limit) return limit;
        return value;
    endfunction

    // Stored sample at a raster position, or zero when it is not positive
    function automatic logic [SUM_OUT_W-1:0] positive_part(int unsigned pos, int unsigned span);
        logic [SAMPLE_W-1:0] v;
        v = line_mem[(pos % span) % STORE_DEPTH];
        return v[SAMPLE_W-1] ? '0 : SUM_OUT_W'(v);
    endfunction

    task automatic clear_matrix();
        foreach (line_mem[i]) line_mem[i] = '0;
        samples_taken = 0;
        cells_sent    = 0;
        next_row      = 0;
        next_col      = 0;
    endtask

    // Predict the next cell in raster order and advance the position
    task automatic predict_next_cell(int unsigned rows, int unsigned cols);
        int unsigned          span;
        int unsigned          p;
        logic [SUM_OUT_W-1:0] sum;
        cell_sum_t            pred;
        span = 2 * cols + 1;
        p    = cells_sent;
        sum  = '0;
        if (next_row > 0)        sum += positive_part(p - cols, span);
        if (next_row + 1 < rows) sum += positive_part(p + cols, span);
        if (next_col > 0)        sum += positive_part(p - 1, span);
        if (next_col + 1 < cols) sum += positive_part(p + 1, span);
        pred.sum        = sum;
        pred.row        = POS_W'(next_row);
        pred.col        = POS_W'(next_col);
        pred.final_cell = (p + 1 == rows * cols);
        expected_cells.push_back(pred);
        cells_sent++;
        next_col++;
        if (next_col >= cols) begin
            next_col = 0;
            next_row++;
        end
    endtask

    // Store a sample or act on a drain beat
    task automatic take_beat(kind_t kind, logic [SAMPLE_W-1:0] data);
        int unsigned rows;
        int unsigned cols;
        int unsigned total;
        rows  = dim_in_use(rows_reg, MAX_ROWS);
        cols  = dim_in_use(cols_reg, MAX_COLS);
        total = rows * cols;
        if (kind == KIND_SAMPLE) begin
            if (samples_taken < total) begin
                line_mem[(samples_taken % (2 * cols + 1)) % STORE_DEPTH] = data;
                samples_taken++;
                if (cells_sent < total && samples_taken > cells_sent + cols)
                    predict_next_cell(rows, cols);
            end
        end else if (samples_taken == total && cells_sent < total) begin
            predict_next_cell(rows, cols);
        end
    endtask

    // Compare one result beat with the oldest prediction
    task automatic check_result(logic [M_DATA_W-1:0] data);
        cell_sum_t seen;
        cell_sum_t want;
        seen.sum        = data[SUM_OUT_W-1:0];
        seen.row        = data[SUM_OUT_W +: POS_W];
        seen.col        = data[SUM_OUT_W + POS_W +: POS_W];
        seen.final_cell = data[SUM_OUT_W + 2 * POS_W];
        if (expected_cells.size() == 0) begin
            $display("%0t: result beat with none expected: sum %0d row %0d col %0d final %0d",
                     $time, seen.sum, seen.row, seen.col, seen.final_cell);
            errors++;
            return;
        end
        want = expected_cells.pop_front();
        if (seen !== want) begin
            $display("%0t: result mismatch: expected sum %0d row %0d col %0d final %0d,",
                     $time, want.sum, want.row, want.col, want.final_cell,
                     " actual sum %0d row %0d col %0d final %0d",
                     seen.sum, seen.row, seen.col, seen.final_cell);
            errors++;
        end
    endtask

    // Track registers, input beats and result beats at each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg = 8'd1;
            cols_reg = 8'd1;
            clear_matrix();
            expected_cells.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (reg_idx_t'(paddr[2]) == REG_ROW_COUNT) rows_reg = pwdata[DIM_W-1:0];
                else cols_reg = pwdata[DIM_W-1:0];
                clear_matrix();
            end
            if (s_tvalid && s_tready) take_beat(kind_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) check_result(m_tdata);
        end
        mismatch_count    <= errors;
        cells_outstanding <= expected_cells.size();
    end

endmodule

>>> test/tb_positive_neighbor_sum_stencil.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positive_neighbor_sum_stencil: stimulus and verdict for the stencil block
// Drives directed edge cases, then random matrices of random sizes with
// early drains, surplus samples and cut-off matrices mixed in, under three
// idling phases, one long receiver hold-off and one sender pause.
// ----------------------------------------------------------------------------
module tb_positive_neighbor_sum_stencil;
    import pnss_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int LATENCY_GAP  = 4;
    localparam int HOLD_OFF_LEN = 80;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;   // [31:0] sample
    logic                s_tuser;   // [0] kind
    logic                m_tvalid;
    logic                m_tready;
    // [32:0] neighbor_sum, [39:33] cell_row, [46:40] cell_col, [47] final_cell
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int          mismatch_count;
    int          cells_outstanding;
    int unsigned send_idle_pct = 33;
    int unsigned recv_idle_pct = 76;
    int unsigned hold_off_left = 0;

    positive_neighbor_sum_stencil u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    stencil_sum_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .mismatch_count    (mismatch_count),
        .cells_outstanding (cells_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case results stop coming
    initial begin
        #(2_000_000);
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random back-pressure, or a counted hold-off when requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_left > 0) begin
                m_tready <= 1'b0;
                hold_off_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_beat(kind_t kind, logic [SAMPLE_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid, wait for every predicted cell, then let the pipeline settle
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (cells_outstanding != 0);
        repeat (LATENCY_GAP) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [DIM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Restart the matrix at a new size once the block is idle
    task automatic set_matrix(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
        wait_for_results();
        if ($urandom_range(1)) begin
            write_reg(REG_ROW_COUNT, rows);
            write_reg(REG_COL_COUNT, cols);
        end else begin
            write_reg(REG_COL_COUNT, cols);
            write_reg(REG_ROW_COUNT, rows);
        end
    endtask

    function automatic int unsigned dim_in_use(logic [DIM_W-1:0] value, int unsigned limit);
        if (value == 0) return 1;
        return (value > limit) ? limit : value;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return SAMPLE_W'($urandom_range(1, 1000));
            4: return -SAMPLE_W'($urandom_range(1, 1000));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned      random_items;
        int unsigned      matrix_no;
        int unsigned      rows_eff;
        int unsigned      cols_eff;
        int unsigned      sample_beats;
        logic [DIM_W-1:0] rows_val;
        logic [DIM_W-1:0] cols_val;
        bit               broken;
        bit               tall_done;
        bit               wide_done;

        random_items = 0;
        matrix_no    = 0;
        tall_done    = 1'b0;
        wide_done    = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single cell at the reset size: early drain, one result, late drain, surplus
        send_beat(KIND_DRAIN, 32'hFFFF_FFFF);
        send_beat(KIND_SAMPLE, 32'h7FFF_FFFF);
        send_beat(KIND_DRAIN, '0);
        send_beat(KIND_DRAIN, 32'h5555_AAAA);
        send_beat(KIND_SAMPLE, 32'h8000_0000);

        // Three by three: largest sum at the center, sign extremes elsewhere
        set_matrix(8'd3, 8'd3);
        send_beat(KIND_SAMPLE, 32'h8000_0000);
        send_beat(KIND_SAMPLE, 32'h7FFF_FFFF);
        send_beat(KIND_SAMPLE, 32'h0000_0000);
        send_beat(KIND_SAMPLE, 32'h7FFF_FFFF);
        send_beat(KIND_SAMPLE, 32'h0000_0001);
        send_beat(KIND_SAMPLE, 32'h7FFF_FFFF);
        send_beat(KIND_SAMPLE, 32'hFFFF_FFFF);
        send_beat(KIND_SAMPLE, 32'h7FFF_FFFF);
        send_beat(KIND_SAMPLE, 32'h7FFF_FFFF);
        repeat (3) send_beat(KIND_DRAIN, '0);

        // Random matrices across three idling phases
        while (random_items < RANDOM_ITEMS) begin
            if (random_items < 60) begin
                send_idle_pct = 33;
                recv_idle_pct = 76;
            end else if (random_items < 120) begin
                send_idle_pct = 76;
                recv_idle_pct = 33;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            rows_val = DIM_W'($urandom_range(1, 8));
            cols_val = DIM_W'($urandom_range(1, 8));
            if (matrix_no == 1) begin
                rows_val = 8'd5;
                cols_val = 8'd6;
            end else if (matrix_no == 3) begin
                rows_val = 8'd6;
                cols_val = 8'd4;
            end else if (random_items >= 120 && !tall_done) begin
                // one column at the row limit, both registers out of range
                rows_val  = 8'd255;
                cols_val  = 8'd0;
                tall_done = 1'b1;
            end else if (random_items >= 120 && !wide_done) begin
                rows_val  = 8'd0;
                cols_val  = 8'd255;
                wide_done = 1'b1;
            end
            set_matrix(rows_val, cols_val);
            rows_eff = dim_in_use(rows_val, DEF_MAX_ROWS);
            cols_eff = dim_in_use(cols_val, DEF_MAX_COLS);

            // Now and then cut the matrix short and restart
            broken = (matrix_no > 3) && ($urandom_range(9) == 0) && (rows_eff * cols_eff > 1);
            sample_beats = broken ? $urandom_range(1, rows_eff * cols_eff - 1)
                                  : rows_eff * cols_eff;

            for (int i = 0; i < sample_beats; i++) begin
                if (matrix_no == 1 && i == sample_beats / 2) wait_for_results();
                if (matrix_no == 3 && i == 2 * cols_eff) hold_off_left = HOLD_OFF_LEN;
                if ($urandom_range(11) == 0) send_beat(KIND_DRAIN, $urandom);
                send_beat(KIND_SAMPLE, pick_sample());
                random_items++;
            end
            if (!broken) begin
                if ($urandom_range(3) == 0) send_beat(KIND_SAMPLE, pick_sample());
                for (int j = 0; j < cols_eff; j++) begin
                    send_beat(KIND_DRAIN, $urandom);
                    random_items++;
                end
                if ($urandom_range(3) == 0) send_beat(KIND_DRAIN, $urandom);
            end
            matrix_no++;
        end

        wait_for_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && cells_outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
